FILE: hw/rtl/dpcc_pkg.sv
// dpcc_pkg: shared types, sizes and arithmetic helpers for the
// dual-polarization cross-correlation tile; used by every rtl file
package dpcc_pkg;

    localparam int INTEGRATION_SAMPLES = 64;
    localparam int SAMPLE_BITS         = 16;
    localparam int NUM_X               = 4;
    localparam int NUM_Y               = 3;
    localparam int NUM_BASELINES       = NUM_X * NUM_Y;
    localparam int ACC_W               = 48;
    localparam int BL_W                = 4;
    localparam int CNT_W = (INTEGRATION_SAMPLES > 1) ? $clog2(INTEGRATION_SAMPLES) : 1;

    typedef logic [63:0]              sample_t;
    typedef logic signed [15:0]       comp_t;
    typedef logic signed [31:0]       prod_t;
    typedef logic signed [32:0]       psum_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [ACC_W:0]    wide_t;

    // four products of one pol pair: xr*yr, xi*yi, xi*yr, xr*yi
    typedef prod_t [3:0] quad_t;

    // one baseline: xx re/im, xy re/im, yx re/im, yy re/im
    typedef acc_t [7:0] row_t;

    // one queued sample set with its end-of-integration tag
    typedef struct packed {
        sample_t [NUM_Y-1:0] y;
        sample_t [NUM_X-1:0] x;
        logic                last;
    } item_t;

    localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // signed component k of a packed dual-pol sample
    function automatic comp_t component(sample_t w, int k);
        logic [15:0] lane;
        lane = w[16*k +: 16];
        return comp_t'(signed'(lane[SAMPLE_BITS-1:0]));
    endfunction

    // saturating accumulate of one product sum
    function automatic acc_t sat_add(acc_t a, psum_t p);
        wide_t s;
        s = wide_t'(a) + wide_t'(p);
        if (s > wide_t'(ACC_MAX))
            return ACC_MAX;
        if (s < wide_t'(ACC_MIN))
            return ACC_MIN;
        return acc_t'(s);
    endfunction

endpackage

FILE: hw/rtl/dpcc_front.sv
// dpcc_front: input acceptance and end-of-integration tagging
// depends on dpcc_pkg
module dpcc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dpcc_pkg::sample_t   x0_sample,
    input  dpcc_pkg::sample_t   x1_sample,
    input  dpcc_pkg::sample_t   x2_sample,
    input  dpcc_pkg::sample_t   x3_sample,
    input  dpcc_pkg::sample_t   y0_sample,
    input  dpcc_pkg::sample_t   y1_sample,
    input  dpcc_pkg::sample_t   y2_sample,
    output logic                push_valid,
    input  logic                push_ready,
    output dpcc_pkg::item_t     push_item
);

    logic [dpcc_pkg::CNT_W-1:0] count_reg;
    logic [dpcc_pkg::CNT_W-1:0] count_next;
    logic                       is_last;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign is_last    = (count_reg == dpcc_pkg::CNT_W'(dpcc_pkg::INTEGRATION_SAMPLES - 1));

    // pack the item with its tag
    always_comb
    begin
        push_item.x    = {x3_sample, x2_sample, x1_sample, x0_sample};
        push_item.y    = {y2_sample, y1_sample, y0_sample};
        push_item.last = is_last;
    end

    // sample counter within the integration
    always_comb
    begin
        count_next = count_reg;
        if (in_valid && in_ready)
        begin
            if (is_last)
                count_next = '0;
            else
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

FILE: hw/rtl/dpcc_queue.sv
// dpcc_queue: two-entry queue of tagged sample sets between front and back
// depends on dpcc_pkg
module dpcc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  dpcc_pkg::item_t   push_item,
    output logic              pop_valid,
    input  logic              pop_ready,
    output dpcc_pkg::item_t   pop_item
);

    dpcc_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

FILE: hw/rtl/dpcc_back.sv
// dpcc_back: product stage, saturating accumulators and result drain
// depends on dpcc_pkg
module dpcc_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  dpcc_pkg::item_t                pop_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dpcc_pkg::BL_W-1:0]      baseline,
    output dpcc_pkg::acc_t                 xx_real,
    output dpcc_pkg::acc_t                 xx_imag,
    output dpcc_pkg::acc_t                 xy_real,
    output dpcc_pkg::acc_t                 xy_imag,
    output dpcc_pkg::acc_t                 yx_real,
    output dpcc_pkg::acc_t                 yx_imag,
    output dpcc_pkg::acc_t                 yy_real,
    output dpcc_pkg::acc_t                 yy_imag,
    output logic                           last_baseline
);

    localparam int NB = dpcc_pkg::NUM_BASELINES;

    dpcc_pkg::quad_t prod_reg [NB][4];
    logic            prod_vld_reg;
    logic            prod_last_reg;
    dpcc_pkg::row_t  acc_reg  [NB];
    dpcc_pkg::row_t  acc_new  [NB];
    dpcc_pkg::row_t  snap_reg [NB];
    logic            busy_reg;
    logic [dpcc_pkg::BL_W-1:0] idx_reg;
    logic            acc_ok;
    logic            advance;
    logic            out_xfer;

    assign acc_ok    = prod_vld_reg && (!prod_last_reg || !busy_reg);
    assign advance   = !prod_vld_reg || acc_ok;
    assign pop_ready = advance;
    assign out_xfer  = busy_reg && out_ready;

    // product stage: four products per pol pair per baseline
    always_ff @(posedge clk)
    begin
        if (advance && pop_valid)
        begin
            for (int b = 0; b < NB; b++)
            begin
                for (int xp = 0; xp < 2; xp++)
                begin
                    for (int yp = 0; yp < 2; yp++)
                    begin
                        prod_reg[b][xp*2+yp][0] <=
                            dpcc_pkg::component(pop_item.x[b % dpcc_pkg::NUM_X], 2*xp)
                          * dpcc_pkg::component(pop_item.y[b / dpcc_pkg::NUM_X], 2*yp);
                        prod_reg[b][xp*2+yp][1] <=
                            dpcc_pkg::component(pop_item.x[b % dpcc_pkg::NUM_X], 2*xp+1)
                          * dpcc_pkg::component(pop_item.y[b / dpcc_pkg::NUM_X], 2*yp+1);
                        prod_reg[b][xp*2+yp][2] <=
                            dpcc_pkg::component(pop_item.x[b % dpcc_pkg::NUM_X], 2*xp+1)
                          * dpcc_pkg::component(pop_item.y[b / dpcc_pkg::NUM_X], 2*yp);
                        prod_reg[b][xp*2+yp][3] <=
                            dpcc_pkg::component(pop_item.x[b % dpcc_pkg::NUM_X], 2*xp)
                          * dpcc_pkg::component(pop_item.y[b / dpcc_pkg::NUM_X], 2*yp+1);
                    end
                end
            end
            prod_last_reg <= pop_item.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_vld_reg <= 1'b0;
        else if (advance)
            prod_vld_reg <= pop_valid;
    end

    // saturating sums of the registered products
    always_comb
    begin
        for (int b = 0; b < NB; b++)
        begin
            for (int p = 0; p < 4; p++)
            begin
                acc_new[b][2*p] = dpcc_pkg::sat_add(acc_reg[b][2*p],
                    dpcc_pkg::psum_t'(prod_reg[b][p][0]) + dpcc_pkg::psum_t'(prod_reg[b][p][1]));
                acc_new[b][2*p+1] = dpcc_pkg::sat_add(acc_reg[b][2*p+1],
                    dpcc_pkg::psum_t'(prod_reg[b][p][2]) - dpcc_pkg::psum_t'(prod_reg[b][p][3]));
            end
        end
    end

    // accumulators, cleared at the end of each integration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NB; b++)
                acc_reg[b] <= '0;
        end
        else if (acc_ok)
        begin
            for (int b = 0; b < NB; b++)
                acc_reg[b] <= prod_last_reg ? '0 : acc_new[b];
        end
    end

    // snapshot rows, shifted out one per transfer
    always_ff @(posedge clk)
    begin
        if (acc_ok && prod_last_reg)
        begin
            for (int b = 0; b < NB; b++)
                snap_reg[b] <= acc_new[b];
        end
        else if (out_xfer)
        begin
            for (int b = 0; b < NB - 1; b++)
                snap_reg[b] <= snap_reg[b+1];
        end
    end

    // drain control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (acc_ok && prod_last_reg)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (out_xfer)
        begin
            if (idx_reg == dpcc_pkg::BL_W'(NB - 1))
                busy_reg <= 1'b0;
            idx_reg <= idx_reg + 1'b1;
        end
    end

    assign out_valid     = busy_reg;
    assign baseline      = idx_reg;
    assign last_baseline = (idx_reg == dpcc_pkg::BL_W'(NB - 1));
    assign xx_real       = snap_reg[0][0];
    assign xx_imag       = snap_reg[0][1];
    assign xy_real       = snap_reg[0][2];
    assign xy_imag       = snap_reg[0][3];
    assign yx_real       = snap_reg[0][4];
    assign yx_imag       = snap_reg[0][5];
    assign yy_real       = snap_reg[0][6];
    assign yy_imag       = snap_reg[0][7];

endmodule

FILE: hw/rtl/dual_pol_cross_correlation_tile_unit.sv
// dual_pol_cross_correlation_tile_unit: top level of the correlator tile
// depends on dpcc_pkg, dpcc_front, dpcc_queue, dpcc_back
//
// Usage:
//   Input channel (in_valid/in_ready) carries one time sample of four x and
//   three y dual-pol stations. Output channel (out_valid/out_ready) carries
//   one baseline result per transfer: index, four complex pol products and
//   a flag on the twelfth baseline.
//   Throughput: one sample set per cycle. The 12-transfer dump of an
//   integration overlaps with the next integration; the only stall on input
//   comes when an integration ends while the previous dump is still being
//   drained (set by the single snapshot buffer).
//   Path: the last sample of an integration goes through the queue and
//   then the product stage register before it is added into the
//   accumulators; the snapshot is taken and the first result is valid
//   right after that add.
//   Reset: accumulators, sample counter and all valids clear; no output.
//   Output stall: the snapshot holds; input keeps flowing until the next
//   integration end, then the two-entry queue fills and in_ready drops.
module dual_pol_cross_correlation_tile_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  dpcc_pkg::sample_t              x0_sample,
    input  dpcc_pkg::sample_t              x1_sample,
    input  dpcc_pkg::sample_t              x2_sample,
    input  dpcc_pkg::sample_t              x3_sample,
    input  dpcc_pkg::sample_t              y0_sample,
    input  dpcc_pkg::sample_t              y1_sample,
    input  dpcc_pkg::sample_t              y2_sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dpcc_pkg::BL_W-1:0]      baseline,
    output dpcc_pkg::acc_t                 xx_real,
    output dpcc_pkg::acc_t                 xx_imag,
    output dpcc_pkg::acc_t                 xy_real,
    output dpcc_pkg::acc_t                 xy_imag,
    output dpcc_pkg::acc_t                 yx_real,
    output dpcc_pkg::acc_t                 yx_imag,
    output dpcc_pkg::acc_t                 yy_real,
    output dpcc_pkg::acc_t                 yy_imag,
    output logic                           last_baseline
);

    logic            push_valid;
    logic            push_ready;
    dpcc_pkg::item_t push_item;
    logic            pop_valid;
    logic            pop_ready;
    dpcc_pkg::item_t pop_item;

    // accept and tag
    dpcc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .x0_sample  (x0_sample),
        .x1_sample  (x1_sample),
        .x2_sample  (x2_sample),
        .x3_sample  (x3_sample),
        .y0_sample  (y0_sample),
        .y1_sample  (y1_sample),
        .y2_sample  (y2_sample),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // decoupling queue
    dpcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // multiply, accumulate, drain
    dpcc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .baseline      (baseline),
        .xx_real       (xx_real),
        .xx_imag       (xx_imag),
        .xy_real       (xy_real),
        .xy_imag       (xy_imag),
        .yx_real       (yx_real),
        .yx_imag       (yx_imag),
        .yy_real       (yy_real),
        .yy_imag       (yy_imag),
        .last_baseline (last_baseline)
    );

endmodule

FILE: test/testbench.sv
// testbench: self-checking bench for the dual-pol cross-correlation tile
// depends on dpcc_pkg and dual_pol_cross_correlation_tile_unit
`timescale 1ns / 100ps

module testbench;

    localparam int  NUM_RANDOM  = 240;
    localparam int  CYCLE_LIMIT = 400000;
    localparam logic [47:0] ACC_TOP = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] ACC_BOT = 48'h8000_0000_0000;

    // one baseline dump entry, zero marks a dump typed in as all zero
    typedef struct {
        logic [3:0]  bl;
        logic [47:0] val [8];
        logic        last;
        logic        zero;
    } dump_t;

    // directed row: seven station words
    typedef struct {
        dpcc_pkg::sample_t s [7];
    } row_in_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    dpcc_pkg::sample_t smp [7];
    logic              out_valid;
    logic              out_ready;
    logic [3:0]        baseline;
    dpcc_pkg::acc_t    xx_real, xx_imag, xy_real, xy_imag;
    dpcc_pkg::acc_t    yx_real, yx_imag, yy_real, yy_imag;
    logic              last_baseline;

    // predictor state
    logic signed [47:0] corr_acc [96];
    int                 corr_count;
    dump_t              dump_queue [$];
    logic               zero_dump;

    int    errors;
    int    results_seen;
    int    cycles;
    int    send_idle_pct;
    int    recv_stall_pct;
    row_in_t rows [$];

    dual_pol_cross_correlation_tile_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .x0_sample(smp[0]), .x1_sample(smp[1]), .x2_sample(smp[2]),
        .x3_sample(smp[3]), .y0_sample(smp[4]), .y1_sample(smp[5]),
        .y2_sample(smp[6]),
        .out_valid(out_valid), .out_ready(out_ready),
        .baseline(baseline),
        .xx_real(xx_real), .xx_imag(xx_imag), .xy_real(xy_real), .xy_imag(xy_imag),
        .yx_real(yx_real), .yx_imag(yx_imag), .yy_real(yy_real), .yy_imag(yy_imag),
        .last_baseline(last_baseline)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // cycle counter with timeout
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("%0t timeout", $time);
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // signed lane value at SAMPLE_BITS
    function automatic longint lane_val(dpcc_pkg::sample_t w, int k);
        logic [15:0] lane;
        longint      v;
        lane = w[16*k +: 16];
        v = lane & ((1 << dpcc_pkg::SAMPLE_BITS) - 1);
        if (v >= (1 << (dpcc_pkg::SAMPLE_BITS - 1)))
            v -= (1 << dpcc_pkg::SAMPLE_BITS);
        return v;
    endfunction

    function automatic logic signed [47:0] clamp_add(logic signed [47:0] a, longint p);
        longint s;
        s = longint'(a) + p;
        if (s > longint'(ACC_TOP))
            return ACC_TOP;
        if (s < -longint'(ACC_TOP) - 1)
            return ACC_BOT;
        return s[47:0];
    endfunction

    // accumulate one sample set, queue a dump at integration end
    task automatic correlate(dpcc_pkg::sample_t s [7]);
        int     idx;
        longint xr, xi, yr, yi;
        dump_t  d;
        for (int ys = 0; ys < dpcc_pkg::NUM_Y; ys++)
            for (int xs = 0; xs < dpcc_pkg::NUM_X; xs++)
                for (int xp = 0; xp < 2; xp++)
                    for (int yp = 0; yp < 2; yp++)
                    begin
                        xr = lane_val(s[xs], 2*xp);
                        xi = lane_val(s[xs], 2*xp + 1);
                        yr = lane_val(s[dpcc_pkg::NUM_X+ys], 2*yp);
                        yi = lane_val(s[dpcc_pkg::NUM_X+ys], 2*yp + 1);
                        idx = (ys*dpcc_pkg::NUM_X + xs)*8 + (xp*2 + yp)*2;
                        corr_acc[idx]   = clamp_add(corr_acc[idx], xr*yr + xi*yi);
                        corr_acc[idx+1] = clamp_add(corr_acc[idx+1], xi*yr - xr*yi);
                    end
        corr_count++;
        if (corr_count >= dpcc_pkg::INTEGRATION_SAMPLES)
        begin
            for (int b = 0; b < dpcc_pkg::NUM_BASELINES; b++)
            begin
                d.bl = 4'(b);
                for (int j = 0; j < 8; j++)
                    d.val[j] = corr_acc[b*8 + j];
                d.last = (b == dpcc_pkg::NUM_BASELINES - 1);
                d.zero = zero_dump;
                dump_queue.push_back(d);
            end
            foreach (corr_acc[i])
                corr_acc[i] = '0;
            corr_count = 0;
        end
    endtask

    // send one sample set through the input handshake
    task automatic send_set(dpcc_pkg::sample_t s [7]);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        for (int i = 0; i < 7; i++)
            smp[i] <= s[i];
        do
            @(posedge clk);
        while (!in_ready);
        correlate(s);
    endtask

    function automatic dpcc_pkg::sample_t rand_word(int mode);
        dpcc_pkg::sample_t w;
        w = {$urandom, $urandom};
        // mode 1: full scale corners in every lane for the largest sums
        if (mode == 1)
            for (int k = 0; k < 4; k++)
                w[16*k +: 16] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        return w;
    endfunction

    // receiver: stall at random, check each transfer
    initial
    begin
        dump_t       e;
        logic [47:0] got [8];
        logic [47:0] tv;
        out_ready = 1'b0;
        results_seen = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = '{xx_real, xx_imag, xy_real, xy_imag,
                        yx_real, yx_imag, yy_real, yy_imag};
                results_seen++;
                if (dump_queue.size() == 0)
                begin
                    $display("%0t unexpected transfer bl=%0d", $time, baseline);
                    errors++;
                end
                else
                begin
                    e = dump_queue.pop_front();
                    if (baseline !== e.bl || last_baseline !== e.last)
                    begin
                        $display("%0t bl/last exp %0d/%0b got %0d/%0b", $time,
                                 e.bl, e.last, baseline, last_baseline);
                        errors++;
                    end
                    for (int j = 0; j < 8; j++)
                    begin
                        tv = e.zero ? 48'h0 : e.val[j];
                        if (got[j] !== e.val[j] || got[j] !== tv)
                        begin
                            $display("%0t bl %0d field %0d exp %h got %h", $time,
                                     e.bl, j, tv, got[j]);
                            errors++;
                        end
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // stimulus
    initial
    begin
        row_in_t           r;
        dpcc_pkg::sample_t s [7];
        int                mode;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        zero_dump = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        foreach (smp[i])
            smp[i] = '0;
        foreach (corr_acc[i])
            corr_acc[i] = '0;
        corr_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: zeros, unit, extremes, high lanes, mixed block
        r.s = '{default: 64'h0};                      rows.push_back(r);
        r.s = '{default: 64'h0000_0000_0000_0001};    rows.push_back(r);
        r.s = '{default: 64'h8000_8000_8000_8000};    rows.push_back(r);
        r.s = '{default: 64'h7FFF_7FFF_7FFF_7FFF};    rows.push_back(r);
        r.s = '{default: 64'hFFFF_FFFF_FFFF_FFFF};    rows.push_back(r);
        r.s = '{64'h0001_0000_0000_0001, 64'h0, 64'h0, 64'h0001_0001_0001_0001,
                64'h0000_0001_0001_0000, 64'h8000_7FFF_8000_7FFF, 64'h5555_AAAA_5555_AAAA};
        rows.push_back(r);
        // pad to end of first integration with zero sets: dump is pure predictor
        foreach (rows[i])
            send_set(rows[i].s);
        for (int i = rows.size(); i < dpcc_pkg::INTEGRATION_SAMPLES; i++)
        begin
            s = '{default: 64'h0};
            send_set(s);
        end

        // directed integration of all zeros: every field typed as zero
        zero_dump = 1'b1;
        s = '{default: 64'h0};
        repeat (dpcc_pkg::INTEGRATION_SAMPLES) send_set(s);
        zero_dump = 1'b0;

        // random phases: quiet, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 71 : (ph == 3) ? 8 : 0;
            recv_stall_pct = (ph == 2) ? 71 : (ph == 3) ? 8 : 0;
            mode = (ph == 2) ? 1 : 0;
            for (int i = 0; i < NUM_RANDOM / 4; i++)
            begin
                foreach (s[k])
                    s[k] = rand_word(mode == 1 || $urandom_range(9) == 0);
                send_set(s);
            end
        end
        // finish the open integration so every sample is dumped
        while (corr_count != 0)
        begin
            foreach (s[k])
                s[k] = rand_word(0);
            send_set(s);
        end
        in_valid <= 1'b0;

        while (dump_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("covered %0d baseline transfers over corner and random sample sets",
                 results_seen);
        $display("idle phases: none, sender 71%%, receiver 71%%, both 8%%");
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
